@@ sv/rational_arith_unit_defines.svh @@
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_DEFINES_SVH
`define RATIONAL_ARITH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rational_arith_unit check failed");
`define RAU_NEVER(lbl, expr) `RAU_ASSERT(lbl, !(expr))
`else
`define RAU_ASSERT(lbl, prop)
`define RAU_NEVER(lbl, expr)
`endif
`endif

@@ sv/rau_pkg.sv @@
// Shared types and constants of the rational arithmetic unit
package rau_pkg;
  localparam int FUNC_W    = 3;
  localparam int RES_NUM_W = 32;
  localparam int RES_DEN_W = 31;

  typedef enum logic [FUNC_W-1:0] {
    FN_ADD  = 3'd0,
    FN_SUB  = 3'd1,
    FN_MUL  = 3'd2,
    FN_DIV  = 3'd3,
    FN_NORM = 3'd4
  } func_t;
endpackage

@@ sv/rau_if.sv @@
// Request and response channel interfaces
interface rau_req_if import rau_pkg::*; #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic signed [W-1:0] a_num;
  logic signed [W-1:0] a_den;
  logic signed [W-1:0] b_num;
  logic signed [W-1:0] b_den;
  modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [RES_NUM_W-1:0] res_num;
  logic [RES_DEN_W-1:0]        res_den;
  logic                        zero_den_error;
  modport source (output valid, res_num, res_den, zero_den_error, input ready);
  modport sink (input valid, res_num, res_den, zero_den_error, output ready);
endinterface

@@ sv/rau_front.sv @@
// Front end: accept a transaction, form cross products, classify and push
module rau_front import rau_pkg::*; #(
  parameter int W = 16
) (
  input  logic               clk,
  input  logic               rst,
  rau_req_if.sink            req,
  output logic               push_valid,
  input  logic               push_ready,
  output logic [4*W+2:0]     push_data
);
  localparam int PW = 2 * W;
  localparam int NW = 2 * W + 1;
  localparam int MW = 2 * W;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

  fstate_t             state;
  logic                sub_op;
  logic                sum_op;
  logic signed [W-1:0] x0, y0, x1, y1, x2, y2;
  logic signed [PW-1:0] p0, p1, p2;
  logic signed [NW-1:0] n, d;
  logic [NW-1:0]        nm, dm;
  logic signed [W-1:0]  one;

  assign one = {{(W-1){1'b0}}, 1'b1};
  assign req.ready = (state == F_IDLE);

  always_comb begin
    if (sum_op) begin
      n = sub_op ? NW'(p0) - NW'(p1) : NW'(p0) + NW'(p1);
    end else begin
      n = NW'(p0);
    end
    d  = NW'(p2);
    nm = n[NW-1] ? -n : n;
    dm = d[NW-1] ? -d : d;
  end

  assign push_valid = (state == F_PUSH);
  assign push_data  = {(d == '0), n[NW-1] && (d != '0), d[NW-1] && (d != '0),
                       (d == '0) ? '0 : nm[MW-1:0], (d == '0) ? '0 : dm[MW-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (req.valid) begin
            state  <= F_MUL;
            sum_op <= (req.func inside {FN_ADD, FN_SUB});
            sub_op <= (req.func == FN_SUB);
            x0 <= req.a_num;
            x1 <= req.b_num;
            y1 <= req.a_den;
            x2 <= req.a_den;
            unique case (req.func) inside
              FN_ADD, FN_SUB: begin
                y0 <= req.b_den;
                y2 <= req.b_den;
              end
              FN_MUL: begin
                y0 <= req.b_num;
                y2 <= req.b_den;
              end
              FN_DIV: begin
                y0 <= req.b_den;
                y2 <= req.b_num;
              end
              default: begin
                y0 <= one;
                y2 <= one;
              end
            endcase
          end
        end
        F_MUL: begin
          p0    <= x0 * y0;
          p1    <= x1 * y1;
          p2    <= x2 * y2;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (push_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule

@@ sv/rau_queue.sv @@
// Two-entry queue between front and back end
module rau_queue #(
  parameter int DW = 67
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [DW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [DW-1:0] pop_data
);
  logic [DW-1:0] mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

@@ sv/rau_back.sv @@
// Back end: binary GCD, two exact divisions, sign fix-up and output register
`include "rational_arith_unit_defines.svh"
module rau_back import rau_pkg::*; #(
  parameter int W = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  logic [4*W+2:0] pop_data,
  rau_rsp_if.source      rsp
);
  localparam int MW = 2 * W;
  localparam int CW = $clog2(MW);
  localparam int XW = (MW > RES_NUM_W) ? MW : RES_NUM_W;

  typedef enum logic [2:0] {B_IDLE, B_GCD, B_DIVN, B_DIVD, B_OUT} bstate_t;

  bstate_t       state;
  logic          err, nneg, dneg;
  logic [MW-1:0] nm, dm, gx, gy, g, qn, qd, quo, quo_next;
  logic [CW-1:0] gk, cnt;
  logic [MW:0]   rem, rem_sh, rem_next;
  logic [XW-1:0] qn_x, qd_x, rn_x;
  logic          neg;

  assign pop_ready = (state == B_IDLE);

  always_comb begin
    rem_sh = {rem[MW-1:0], quo[MW-1]};
    if (rem_sh >= {1'b0, g}) begin
      rem_next = rem_sh - {1'b0, g};
      quo_next = {quo[MW-2:0], 1'b1};
    end else begin
      rem_next = rem_sh;
      quo_next = {quo[MW-2:0], 1'b0};
    end
  end

  assign qn_x = XW'(qn);
  assign qd_x = XW'(qd);
  assign neg  = (qn != '0) && (nneg != dneg);
  assign rn_x = neg ? -qn_x : qn_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      if (state == B_OUT && (!rsp.valid || rsp.ready)) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (pop_valid) begin
            {err, nneg, dneg, nm, dm} <= pop_data;
            gx    <= pop_data[2*MW-1:MW];
            gy    <= pop_data[MW-1:0];
            gk    <= '0;
            qn    <= '0;
            qd    <= {{(MW-1){1'b0}}, 1'b1};
            state <= pop_data[2*MW+2] ? B_OUT : B_GCD;
          end
        end
        B_GCD: begin
          if (gx == '0 || gy == '0) begin
            g     <= (gx | gy) << gk;
            quo   <= nm;
            rem   <= '0;
            cnt   <= '0;
            state <= B_DIVN;
          end else if (!gx[0] && !gy[0]) begin
            gx <= gx >> 1;
            gy <= gy >> 1;
            gk <= gk + 1'b1;
          end else if (!gx[0]) begin
            gx <= gx >> 1;
          end else if (!gy[0]) begin
            gy <= gy >> 1;
          end else if (gx >= gy) begin
            gx <= (gx - gy) >> 1;
          end else begin
            gy <= (gy - gx) >> 1;
          end
        end
        B_DIVN: begin
          if (cnt == CW'(MW - 1)) begin
            qn    <= quo_next;
            quo   <= dm;
            rem   <= '0;
            cnt   <= '0;
            state <= B_DIVD;
          end else begin
            cnt <= cnt + 1'b1;
            quo <= quo_next;
            rem <= rem_next;
          end
        end
        B_DIVD: begin
          cnt <= cnt + 1'b1;
          quo <= quo_next;
          rem <= rem_next;
          if (cnt == CW'(MW - 1)) begin
            qd    <= quo_next;
            state <= B_OUT;
          end
        end
        B_OUT: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.res_num        <= rn_x[RES_NUM_W-1:0];
            rsp.res_den        <= qd_x[RES_DEN_W-1:0];
            rsp.zero_den_error <= err;
            state              <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  `RAU_ASSERT(a_err_gives_zero, rsp.valid && rsp.zero_den_error |-> rsp.res_num == '0 && rsp.res_den == RES_DEN_W'(1))
  `RAU_NEVER(a_den_nonzero, rsp.valid && rsp.res_den == '0)
  `RAU_NEVER(a_gcd_live, state == B_GCD && gx == '0 && gy == '0)
endmodule

@@ sv/rational_arith_unit.sv @@
// Top level of the rational arithmetic unit
// Each transaction carries an operation (add, subtract, multiply, divide,
// normalise) and two fractions; the result is the fraction in lowest terms
// with a positive denominator, or 0/1 with zero_den_error set when the
// denominator is zero. Items are handled one at a time in the back end: the
// front end registers the operands, forms the cross products and pushes
// them into the queue, then the back end runs a binary GCD and two one-bit-a-
// cycle divisions before the output register; a zero denominator skips the
// GCD and divisions. A two-entry queue lets the front end take the next
// item while the back end is busy.
module rational_arith_unit import rau_pkg::*; #(
  parameter int OPERAND_WIDTH = 16
) (
  input logic       clk,
  input logic       rst,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);
  localparam int DW = 4 * OPERAND_WIDTH + 3;

  logic          f_valid, f_ready, b_valid, b_ready;
  logic [DW-1:0] f_data, b_data;

  rau_front #(.W(OPERAND_WIDTH)) u_front (
    .clk(clk), .rst(rst), .req(req),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data)
  );

  rau_queue #(.DW(DW)) u_queue (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_data),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data)
  );

  rau_back #(.W(OPERAND_WIDTH)) u_back (
    .clk(clk), .rst(rst),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_data), .rsp(rsp)
  );
endmodule
